>>> src/dpd_pkg.sv
// Shared constants, types and helper functions of the duplicate pair detector.
package dpd_pkg;

    localparam int BUCKETS  = 1024;
    localparam int WAYS     = 8;
    localparam int DEPTH    = BUCKETS * WAYS;
    localparam int BUCKET_W = $clog2(BUCKETS);
    localparam int CNT_W    = $clog2(WAYS + 1);
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int ID_W     = 64;
    localparam int KLO_W    = 64;
    localparam int KHI_W    = 16;

    typedef enum logic [1:0] {
        OUTCOME_NEW  = 2'd0,
        OUTCOME_DUP  = 2'd1,
        OUTCOME_DROP = 2'd2
    } outcome_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]  owner;
        logic [KLO_W-1:0] key_lo;
        logic [KHI_W-1:0] key_hi;
    } entry_t;

    typedef struct packed {
        logic     load;
        logic     clear;
        logic     scan;
        logic     insert;
        logic     set_result;
        outcome_t result_code;
        logic     emit;
    } dp_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic hit;
        logic scan_end;
        logic full;
        logic out_free;
    } dp_sts_t;

    // Bucket of an identifier: low bits of its absolute value. BUCKETS is a
    // power of two, so only the low bits of the negation are needed.
    function automatic logic [BUCKET_W-1:0] bucket_of(input logic [ID_W-1:0] id);
        logic [BUCKET_W-1:0] low;
        low = id[BUCKET_W-1:0];
        if (id[ID_W-1]) begin
            return (~low) + BUCKET_W'(1);
        end
        return low;
    endfunction

endpackage

>>> src/duplicate_pair_detector.sv
// Top level of the duplicate pair detector: controller and datapath.
//
// The block takes one word per item on the s_ channel: a signed identifier
// and a key of up to ten bytes. It answers with exactly one word on the m_
// channel: outcome new (pair stored), duplicate (pair seen before, echo_id
// carries the identifier) or dropped (bucket full, echo_id is zero).
// Pairs are kept in 1024 buckets of 8 ways, chosen by the absolute value of
// the identifier. Each bucket has a fill count; its valid ways are searched
// one per cycle through a single registered memory read port.
// The time from acceptance to the result word grows with the number of ways
// already filled in the item's bucket, and is shorter when a duplicate turns
// up early, since the way scan ends there.
// The controller is back in idle as the word appears and then takes the next
// item; one item is in work at a time.
// After reset the block walks the 1024 fill counts to zero, one a cycle,
// and holds s_ready low until the walk is done.
// A finished word waits in the output register while m_ready is low; the
// next item is still accepted and processed, and only its result waits
// for the output register to empty.
module duplicate_pair_detector (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [dpd_pkg::ID_W-1:0]    s_ant_id,
    input  logic [dpd_pkg::KLO_W-1:0]   s_key_low,
    input  logic [dpd_pkg::KHI_W-1:0]   s_key_high,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_outcome,
    output logic [dpd_pkg::ID_W-1:0]    m_echo_id
);
    import dpd_pkg::*;

    // Commands flow from the controller to the datapath, status flows back.
    dp_cmd_t cmd;
    dp_sts_t sts;

    dpd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    dpd_datapath u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .sts        (sts),
        .s_ant_id   (s_ant_id),
        .s_key_low  (s_key_low),
        .s_key_high (s_key_high),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_outcome  (m_outcome),
        .m_echo_id  (m_echo_id)
    );

endmodule

>>> src/dpd_datapath.sv
// Datapath of the duplicate pair detector: fill counts, entry store, compare, output word.
module dpd_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  dpd_pkg::dp_cmd_t            cmd,
    output dpd_pkg::dp_sts_t            sts,
    input  logic [dpd_pkg::ID_W-1:0]    s_ant_id,
    input  logic [dpd_pkg::KLO_W-1:0]   s_key_low,
    input  logic [dpd_pkg::KHI_W-1:0]   s_key_high,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [1:0]                  m_outcome,
    output logic [dpd_pkg::ID_W-1:0]    m_echo_id
);
    import dpd_pkg::*;

    // Per-bucket fill counts; ways fill from zero upward and are never freed,
    // so the valid entries of a bucket are exactly ways 0 to count-1.
    logic [CNT_W-1:0] cnt_mem [BUCKETS];
    entry_t           ent_mem [DEPTH];

    logic [CNT_W-1:0]    cnt_rd_reg;
    entry_t              ent_rd_reg;
    logic [ID_W-1:0]     id_reg;
    logic [KLO_W-1:0]    klo_reg;
    logic [KHI_W-1:0]    khi_reg;
    logic [BUCKET_W-1:0] bucket_reg;
    logic [CNT_W-1:0]    way_reg;
    outcome_t            res_code_reg;
    outcome_t            m_outcome_reg;
    logic [ID_W-1:0]     m_echo_reg;

    logic [BUCKET_W-1:0] clr_idx_reg, clr_idx_next;
    logic                pend_reg, pend_next;
    logic                m_valid_reg, m_valid_next;

    logic                can_issue;
    logic                scan_issue;
    logic                hit;
    logic [ADDR_W-1:0]   scan_addr;
    logic [ADDR_W-1:0]   ins_addr;
    logic                cnt_we;
    logic [BUCKET_W-1:0] cnt_waddr;
    logic [CNT_W-1:0]    cnt_wdata;
    entry_t              probe;

    assign probe      = '{owner: id_reg, key_lo: klo_reg, key_hi: khi_reg};
    assign can_issue  = (way_reg < cnt_rd_reg);
    assign scan_issue = cmd.scan && can_issue;
    assign hit        = pend_reg && (ent_rd_reg == probe);
    assign scan_addr  = ADDR_W'(bucket_reg) * ADDR_W'(WAYS) + ADDR_W'(way_reg);
    assign ins_addr   = ADDR_W'(bucket_reg) * ADDR_W'(WAYS) + ADDR_W'(cnt_rd_reg);

    assign cnt_we    = cmd.clear || cmd.insert;
    assign cnt_waddr = cmd.clear ? clr_idx_reg : bucket_reg;
    assign cnt_wdata = cmd.clear ? '0 : cnt_rd_reg + CNT_W'(1);

    always_ff @(posedge aclk) begin
        if (cnt_we) begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        if (cmd.load) begin
            cnt_rd_reg <= cnt_mem[bucket_of(s_ant_id)];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            ent_mem[ins_addr] <= probe;
        end
        if (scan_issue) begin
            ent_rd_reg <= ent_mem[scan_addr];
        end
    end

    always_comb begin
        clr_idx_next = cmd.clear ? clr_idx_reg + BUCKET_W'(1) : clr_idx_reg;
        pend_next    = scan_issue;
        m_valid_next = m_valid_reg;
        if (cmd.emit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_idx_reg <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            clr_idx_reg <= clr_idx_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            id_reg     <= s_ant_id;
            klo_reg    <= s_key_low;
            khi_reg    <= s_key_high;
            bucket_reg <= bucket_of(s_ant_id);
            way_reg    <= '0;
        end else if (scan_issue) begin
            way_reg <= way_reg + CNT_W'(1);
        end
        if (cmd.set_result) begin
            res_code_reg <= cmd.result_code;
        end
        if (cmd.emit) begin
            m_outcome_reg <= res_code_reg;
            m_echo_reg    <= (res_code_reg == OUTCOME_DUP) ? id_reg : '0;
        end
    end

    assign sts.clear_done = (clr_idx_reg == BUCKET_W'(BUCKETS - 1));
    assign sts.hit        = hit;
    assign sts.scan_end   = !can_issue && !hit;
    assign sts.full       = (cnt_rd_reg == CNT_W'(WAYS));
    assign sts.out_free   = !m_valid_reg || m_ready;

    assign m_valid   = m_valid_reg;
    assign m_outcome = m_outcome_reg;
    assign m_echo_id = m_echo_reg;

endmodule

>>> src/dpd_ctrl.sv
// Controller state machine of the duplicate pair detector.
module dpd_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  dpd_pkg::dp_sts_t sts,
    output dpd_pkg::dp_cmd_t cmd
);
    import dpd_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (sts.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                if (sts.hit || sts.scan_end) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        cmd             = '0;
        cmd.result_code = OUTCOME_NEW;
        s_ready         = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear = 1'b1;
            end
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_LOOKUP: begin
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.hit) begin
                    cmd.set_result  = 1'b1;
                    cmd.result_code = OUTCOME_DUP;
                end else if (sts.scan_end) begin
                    cmd.set_result = 1'b1;
                    if (sts.full) begin
                        cmd.result_code = OUTCOME_DROP;
                    end else begin
                        cmd.insert      = 1'b1;
                        cmd.result_code = OUTCOME_NEW;
                    end
                end
            end
            ST_EMIT: begin
                cmd.emit = sts.out_free;
            end
            default: begin
            end
        endcase
    end

endmodule

>>> sim/tb_duplicate_pair_detector.sv
`timescale 1ns / 100ps
// Self-checking testbench for the duplicate pair detector: directed corners, random traffic.
module tb_duplicate_pair_detector;
    import dpd_pkg::*;

    // One expected answer of the block, in the order in which items went in.
    typedef struct packed {
        outcome_t        outcome;
        logic [ID_W-1:0] echo_id;
    } result_word_t;

    // How the result side behaves when no long hold-off is running.
    typedef enum logic {
        RX_ALWAYS,
        RX_RANDOM
    } rx_mode_t;

    localparam int HOT_BUCKETS = 6;
    localparam int ID_POOL     = 48;
    localparam int KEY_POOL    = 4;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [ID_W-1:0]    s_ant_id;
    logic [KLO_W-1:0]   s_key_low;
    logic [KHI_W-1:0]   s_key_high;
    logic               m_valid;
    logic               m_ready;
    logic [1:0]         m_outcome;
    logic [ID_W-1:0]    m_echo_id;

    // Shadow copy of the pair store. It starts empty, as the block does once its
    // clearing walk after reset is over; reset is applied only once.
    logic [ID_W-1:0]    seen_owner  [DEPTH];
    logic [KLO_W-1:0]   seen_key_lo [DEPTH];
    logic [KHI_W-1:0]   seen_key_hi [DEPTH];
    bit                 seen_valid  [DEPTH];

    result_word_t       pending_results[$];
    int                 mismatch_count = 0;

    // The long receiver hold-off is requested here and counted down in the
    // receiver process itself.
    int                 hold_request = 0;
    rx_mode_t           rx_mode = RX_ALWAYS;

    // Random traffic draws most identifiers from a pool that lands in a few
    // buckets, so that buckets fill, pairs repeat and pairs get dropped.
    logic [ID_W-1:0]    id_pool  [ID_POOL];
    logic [KLO_W-1:0]   klo_pool [KEY_POOL];
    logic [KHI_W-1:0]   khi_pool [KEY_POOL];

    duplicate_pair_detector DUT (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_ant_id   (s_ant_id),
        .s_key_low  (s_key_low),
        .s_key_high (s_key_high),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_outcome  (m_outcome),
        .m_echo_id  (m_echo_id)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Looks a pair up in the shadow store and inserts it when it is new. The
    // bucket is the full 64-bit magnitude of the identifier modulo the bucket
    // count, so the most negative identifier maps through 2^63 without overflow.
    function automatic result_word_t classify_pair(input logic [ID_W-1:0]  id,
                                                   input logic [KLO_W-1:0] klo,
                                                   input logic [KHI_W-1:0] khi);
        logic [ID_W-1:0] magnitude;
        int              base;
        int              free_slot;
        result_word_t    res;
        magnitude = id[ID_W-1] ? (~id + ID_W'(1)) : id;
        base      = int'(magnitude % ID_W'(BUCKETS)) * WAYS;
        free_slot = -1;
        for (int w = 0; w < WAYS; w++) begin
            if (seen_valid[base + w]) begin
                // All 80 key bits take part, zero bytes in the middle included.
                if (seen_owner[base + w] == id && seen_key_lo[base + w] == klo &&
                    seen_key_hi[base + w] == khi) begin
                    res.outcome = OUTCOME_DUP;
                    res.echo_id = id;
                    return res;
                end
            end else if (free_slot < 0) begin
                free_slot = base + w;
            end
        end
        res.echo_id = '0;
        if (free_slot >= 0) begin
            seen_owner[free_slot]  = id;
            seen_key_lo[free_slot] = klo;
            seen_key_hi[free_slot] = khi;
            seen_valid[free_slot]  = 1'b1;
            res.outcome            = OUTCOME_NEW;
        end else begin
            res.outcome = OUTCOME_DROP;
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Both handshakes are observed at the rising edge. An accepted input word
    // is classified at once, so the expectation queue always follows the order
    // in which the block took the items; a result word is checked against the
    // oldest expectation.
    always @(posedge aclk) begin : word_monitor
        result_word_t want;
        if (aresetn === 1'b1) begin
            if (s_valid && s_ready === 1'b1) begin
                pending_results.push_back(classify_pair(s_ant_id, s_key_low, s_key_high));
            end
            if (m_valid === 1'b1 && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result word with no item pending, outcome %0d",
                                              m_outcome));
                end else begin
                    want = pending_results.pop_front();
                    if (m_outcome !== want.outcome) begin
                        report_mismatch($sformatf("outcome %0d, expected %0d",
                                                  m_outcome, want.outcome));
                    end
                    if (m_echo_id !== want.echo_id) begin
                        report_mismatch($sformatf("echo_id %h, expected %h",
                                                  m_echo_id, want.echo_id));
                    end
                end
            end
        end
    end

    // Result side: either always ready or ready/stalled in runs of random length.
    // A requested hold-off overrides both and keeps m_ready low until it has counted down.
    initial begin : receiver
        int run_left;
        int hold_left;
        bit run_ready;
        run_left  = 0;
        hold_left = 0;
        run_ready = 1'b1;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request > 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_ready = 1'b0;
                hold_left--;
            end else if (rx_mode == RX_ALWAYS) begin
                m_ready = 1'b1;
            end else begin
                if (run_left == 0) begin
                    run_ready = ($urandom_range(0, 99) >= 40);
                    run_left  = $urandom_range(1, 8);
                end
                m_ready = run_ready;
                run_left--;
            end
        end
    end

    // Offers one word at the falling edge and returns at the rising edge that
    // accepts it. Valid stays high, so a following call keeps the stream going;
    // idle_sender lowers it.
    task automatic send_word(input logic [ID_W-1:0]  id,
                             input logic [KLO_W-1:0] klo,
                             input logic [KHI_W-1:0] khi);
        @(negedge aclk);
        s_valid    = 1'b1;
        s_ant_id   = id;
        s_key_low  = klo;
        s_key_high = khi;
        @(posedge aclk);
        while (s_ready !== 1'b1) begin
            @(posedge aclk);
        end
    endtask

    task automatic idle_sender(input int cycles);
        repeat (cycles) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
    endtask

    // The sender pauses until every expected word has come back. The block
    // answers every item, so a short settling time after that is enough.
    task automatic wait_for_results();
        idle_sender(1);
        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (16) @(posedge aclk);
    endtask

    task automatic build_pools();
        int              hot [HOT_BUCKETS];
        logic [ID_W-1:0] magnitude;
        hot = '{0, 3, 77, 511, 512, 1023};
        for (int k = 0; k < ID_POOL; k++) begin
            // Random upper bits, positive magnitude, bucket fixed by the low bits.
            magnitude = {1'b0, 53'({$urandom(), $urandom()}), 10'(hot[k % HOT_BUCKETS])};
            id_pool[k] = ($urandom_range(0, 1) == 1) ? (~magnitude + ID_W'(1)) : magnitude;
        end
        for (int k = 0; k < KEY_POOL; k++) begin
            klo_pool[k] = {$urandom(), $urandom()};
            khi_pool[k] = 16'($urandom());
        end
        // One pooled key has a zero byte with text after it.
        klo_pool[1][23:16] = 8'h00;
    endtask

    task automatic pick_pair(output logic [ID_W-1:0]  id,
                             output logic [KLO_W-1:0] klo,
                             output logic [KHI_W-1:0] khi);
        int roll;
        int k;
        roll = $urandom_range(0, 99);
        k    = $urandom_range(0, KEY_POOL - 1);
        if (roll < 70) begin
            id  = id_pool[$urandom_range(0, ID_POOL - 1)];
            klo = klo_pool[k];
            khi = khi_pool[k];
        end else if (roll < 85) begin
            id  = id_pool[$urandom_range(0, ID_POOL - 1)];
            klo = {$urandom(), $urandom()};
            khi = 16'($urandom());
        end else begin
            id  = {$urandom(), $urandom()};
            klo = {$urandom(), $urandom()};
            khi = 16'($urandom());
        end
    endtask

    // Field extremes, the most negative identifier, keys that differ only
    // after a zero byte or only in the upper two bytes, and one bucket driven
    // past full with a duplicate and a repeated drop behind it.
    task automatic test_corner_items();
        logic [ID_W-1:0]  id_min;
        logic [ID_W-1:0]  id_max;
        logic [KLO_W-1:0] key_a;
        logic [KLO_W-1:0] key_b;
        logic [KLO_W-1:0] key_c;
        id_min = 64'h8000_0000_0000_0000;
        id_max = 64'h7FFF_FFFF_FFFF_FFFF;
        key_a  = 64'h0000_0064_6300_6261;   // "ab", zero byte, "cd"
        key_b  = 64'h0000_0065_6300_6261;   // same up to the zero byte, then "ce"
        key_c  = 64'h0000_0000_0074_6E61;
        rx_mode = RX_ALWAYS;
        send_word(id_min, '1, '1);
        send_word(id_min, '1, '1);
        send_word('0, '0, '0);
        send_word(id_max, key_a, '0);
        send_word(id_max, key_b, '0);
        send_word(id_max, key_a, '0);
        send_word(64'd42, key_c, 16'h0001);
        send_word(64'd42, key_c, 16'h0100);
        send_word('1, key_c, '0);
        send_word(64'd1, key_c, '0);
        // Eight owners of bucket 5 fill it, the ninth is dropped.
        for (int k = 0; k < 4; k++) begin
            send_word(ID_W'(5 + 1024 * k), key_c, '0);
            send_word(~ID_W'(5 + 1024 * k) + ID_W'(1), key_c, '0);
        end
        send_word(ID_W'(5 + 1024 * 4), key_c, '0);
        // A stored pair is still found as a duplicate in a full bucket.
        send_word(ID_W'(5), key_c, '0);
        send_word(ID_W'(5 + 1024 * 4), key_c, '0);
        wait_for_results();
    endtask

    // Random traffic in bursts with random gaps, against a stalling receiver.
    // Halfway through, the sender stops until everything has come back.
    task automatic test_bursts_with_stalls(input int n_items);
        logic [ID_W-1:0]  id;
        logic [KLO_W-1:0] klo;
        logic [KHI_W-1:0] khi;
        int               sent;
        int               burst;
        rx_mode = RX_RANDOM;
        sent    = 0;
        while (sent < n_items) begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst && sent < n_items; i++) begin
                pick_pair(id, klo, khi);
                send_word(id, klo, khi);
                sent++;
                if (sent == n_items / 2) begin
                    wait_for_results();
                end
            end
            idle_sender($urandom_range(0, 10));
        end
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while the sender keeps
    // offering words, so the output register fills and s_ready drops.
    task automatic test_output_hold(input int n_items);
        logic [ID_W-1:0]  id;
        logic [KLO_W-1:0] klo;
        logic [KHI_W-1:0] khi;
        rx_mode = RX_RANDOM;
        for (int i = 0; i < n_items; i++) begin
            pick_pair(id, klo, khi);
            send_word(id, klo, khi);
            if (i == 2) begin
                hold_request = 300;
            end
        end
        wait_for_results();
    endtask

    // A long stretch with no idling on either side.
    task automatic test_back_to_back(input int n_items);
        logic [ID_W-1:0]  id;
        logic [KLO_W-1:0] klo;
        logic [KHI_W-1:0] khi;
        rx_mode = RX_ALWAYS;
        for (int i = 0; i < n_items; i++) begin
            pick_pair(id, klo, khi);
            send_word(id, klo, khi);
        end
        wait_for_results();
    endtask

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_ant_id   = '0;
        s_key_low  = '0;
        s_key_high = '0;
        build_pools();
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        // After reset the block first clears the bucket counts; send_word simply
        // waits for s_ready through that.
        test_corner_items();
        test_bursts_with_stalls(450);
        test_output_hold(80);
        test_back_to_back(300);
        repeat (30) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Safety net, far beyond the slowest correct run.
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
